### rtl/fwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwf_pkg: shared types for the duplicate filter
// Hash word type, item modes, controller states and chain control.
// ----------------------------------------------------------------------------
package fwf_pkg;

  localparam int HashWords = 4;
  localparam int WordW     = 64;
  localparam int CfgW      = 9;

  typedef logic [HashWords-1:0][WordW-1:0] hash_t;

  typedef enum logic [1:0] {
    MODE_MARK  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  typedef struct packed {
    logic rotate;
    logic insert;
  } chain_ctrl_t;

endpackage

### rtl/fwf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwf_if: handshake channels of the duplicate filter
// Input word carries mode, hash and block number; output word carries the
// presence flag, entry count and tip.
// ----------------------------------------------------------------------------
interface fwf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] hash_word_0;
  logic [63:0] hash_word_1;
  logic [63:0] hash_word_2;
  logic [63:0] hash_word_3;
  logic [63:0] blk_height;

  modport source (output valid, mode, hash_word_0, hash_word_1, hash_word_2,
                  hash_word_3, blk_height, input ready);
  modport sink   (input valid, mode, hash_word_0, hash_word_1, hash_word_2,
                  hash_word_3, blk_height, output ready);
endinterface

interface fwf_out_if;
  logic        valid;
  logic        ready;
  logic        was_present;
  logic [8:0]  entry_count;
  logic [63:0] tip_number;
  logic        tip_valid;
  logic [63:0] tip_word_0;
  logic [63:0] tip_word_1;
  logic [63:0] tip_word_2;
  logic [63:0] tip_word_3;

  modport source (output valid, was_present, entry_count, tip_number, tip_valid,
                  tip_word_0, tip_word_1, tip_word_2, tip_word_3, input ready);
  modport sink   (input valid, was_present, entry_count, tip_number, tip_valid,
                  tip_word_0, tip_word_1, tip_word_2, tip_word_3, output ready);
endinterface

### rtl/fwf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwf_cell: one window entry
// Holds a 256-bit hash and takes its neighbor's hash when the chain moves.
// ----------------------------------------------------------------------------
module fwf_cell
  import fwf_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  hash_t d_i,
  output hash_t q_o
);

  hash_t hash_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hash_q <= d_i;
    end
  end

  assign q_o = hash_q;

endmodule

### rtl/fwf_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwf_chain: row of window cells
// Cell 0 holds the newest entry. Rotate moves the whole ring by one cell;
// insert pushes the key in at cell 0 and drops the last cell.
// ----------------------------------------------------------------------------
module fwf_chain
  import fwf_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  hash_t       key_i,
  output hash_t       tail_o
);

  hash_t row [DEPTH];
  hash_t head_d;
  logic  move;

  assign move   = ctrl_i.rotate | ctrl_i.insert;
  // wrap the tail back to the head while scanning
  assign head_d = ctrl_i.rotate ? row[DEPTH-1] : key_i;

  fwf_cell u_cell_0 (
    .clk_i (clk_i),
    .en_i  (move),
    .d_i   (head_d),
    .q_o   (row[0])
  );

  for (genvar i = 1; i < DEPTH; i++) begin : g_cell
    fwf_cell u_cell (
      .clk_i (clk_i),
      .en_i  (move),
      .d_i   (row[i-1]),
      .q_o   (row[i])
    );
  end

  assign tail_o = row[DEPTH-1];

endmodule

### rtl/fifo_window_duplicate_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_window_duplicate_filter: FIFO window of recent distinct block hashes
// Marks, queries or clears 256-bit hashes and tracks the highest marked block.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   valid/ready word: mode (mark, query, clear), four hash words and
//          the block number. One word is taken at a time.
//   out_o  valid/ready word: presence flag, entry count and tip, one result
//          word per input word, in order.
//   cfg_we_i/cfg_wdata_i set the window size (0 or above WINDOW means WINDOW)
//          and empty the window and tip. Write only while the block is idle.
// Sequence:
//   Mark and query words walk the ring of WINDOW cells once in SCAN,
//   comparing the cell at the tail with the key, then pass UPDATE and
//   FINISH, where the result is loaded. Clear words go from IDLE straight
//   to FINISH. A new word can be accepted the cycle after the result is
//   loaded, so one word is finished before the next is taken.
// Reset empties the window and tip and sets the size to WINDOW.
// A stalled receiver holds the result in the output register; the next word
//   is still accepted and processed and waits until that register frees.
// ----------------------------------------------------------------------------
module fifo_window_duplicate_filter
  import fwf_pkg::*;
#(
  parameter int WINDOW = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  fwf_in_if.sink           in_i,
  fwf_out_if.source        out_o
);

  localparam int PosW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CntW = $clog2(WINDOW + 1);
  localparam int CmpW = (CntW > CfgW) ? CntW : CfgW;
  localparam logic [PosW-1:0] LastPos = PosW'(WINDOW - 1);

  state_e          state_q, state_d;
  logic [CfgW-1:0] size_cfg_q;
  hash_t           key_hash_q;
  logic [63:0]     key_num_q;
  logic [1:0]      key_mode_q;
  logic [PosW-1:0] pos_q;
  logic            hit_q;
  logic [CntW-1:0] count_q;
  logic [63:0]     tip_num_q;
  logic            tip_valid_q;
  hash_t           tip_digest_q;

  logic            out_valid_q;
  logic            out_present_q;
  logic [CfgW-1:0] out_count_q;
  logic [63:0]     out_tip_num_q;
  logic            out_tip_valid_q;
  hash_t           out_tip_digest_q;

  chain_ctrl_t     ctrl;
  hash_t           tail;
  hash_t           in_hash;
  logic [CntW-1:0] eff_size;
  logic [CmpW-1:0] size_ext;
  logic [CmpW-1:0] count_ext;
  logic            in_fire;
  logic            out_load;
  logic            tail_hit;
  logic            do_insert;

  assign in_hash   = {in_i.hash_word_3, in_i.hash_word_2, in_i.hash_word_1,
                      in_i.hash_word_0};
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire   = in_i.valid & in_i.ready;

  assign size_ext  = CmpW'(size_cfg_q);
  assign eff_size  = ((size_cfg_q == '0) || (size_ext > CmpW'(WINDOW))) ?
                     CntW'(WINDOW) : CntW'(size_ext);
  assign count_ext = CmpW'(count_q);

  assign tail_hit  = (tail == key_hash_q) && (CntW'(pos_q) < count_q);
  assign do_insert = (state_q == ST_UPDATE) && (key_mode_q == MODE_MARK) && !hit_q;
  assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);

  assign ctrl.rotate = (state_q == ST_SCAN);
  assign ctrl.insert = do_insert;

  fwf_chain #(
    .DEPTH (WINDOW)
  ) u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .key_i  (key_hash_q),
    .tail_o (tail)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.mode == MODE_CLEAR) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pos_q == '0) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      size_cfg_q   <= CfgW'(WINDOW);
      pos_q        <= '0;
      hit_q        <= 1'b0;
      count_q      <= '0;
      tip_num_q    <= '0;
      tip_valid_q  <= 1'b0;
      tip_digest_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        size_cfg_q   <= cfg_wdata_i;
        count_q      <= '0;
        tip_num_q    <= '0;
        tip_valid_q  <= 1'b0;
        tip_digest_q <= '0;
      end else if (in_fire && (in_i.mode == MODE_CLEAR)) begin
        count_q      <= '0;
        tip_num_q    <= '0;
        tip_valid_q  <= 1'b0;
        tip_digest_q <= '0;
      end else if (do_insert) begin
        // a full window keeps its count, so its oldest entry drops out of the counted cells
        if (count_q < eff_size) begin
          count_q <= count_q + 1'b1;
        end
        if (key_num_q > tip_num_q) begin
          tip_num_q    <= key_num_q;
          tip_valid_q  <= 1'b1;
          tip_digest_q <= key_hash_q;
        end
      end
      if (in_fire) begin
        pos_q <= LastPos;
        hit_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        pos_q <= pos_q - 1'b1;
        if (tail_hit) begin
          hit_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_hash_q <= in_hash;
      key_num_q  <= in_i.blk_height;
      key_mode_q <= in_i.mode;
    end
    if (out_load) begin
      out_present_q    <= hit_q;
      out_count_q      <= count_ext[CfgW-1:0];
      out_tip_num_q    <= tip_num_q;
      out_tip_valid_q  <= tip_valid_q;
      out_tip_digest_q <= tip_digest_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.was_present = out_present_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.tip_number  = out_tip_num_q;
  assign out_o.tip_valid   = out_tip_valid_q;
  assign out_o.tip_word_0  = out_tip_digest_q[0];
  assign out_o.tip_word_1  = out_tip_digest_q[1];
  assign out_o.tip_word_2  = out_tip_digest_q[2];
  assign out_o.tip_word_3  = out_tip_digest_q[3];

endmodule

### rtl/fwf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwf_checker: port-level checks for the duplicate filter
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module fwf_checker
  import fwf_pkg::*;
#(
  parameter int WINDOW = 256
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             was_present_i,
  input logic [CfgW-1:0]  entry_count_i,
  input logic [63:0]      tip_number_i,
  input logic             tip_valid_i,
  input hash_t            tip_digest_i
);

  localparam int CntMax = (WINDOW > 511) ? 511 : WINDOW;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // one word at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  a_present_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && was_present_i |-> entry_count_i != '0)
    else $error("hit reported on an empty window");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(entry_count_i) <= CntMax)
    else $error("entry count above window");

  a_tip_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !tip_valid_i |-> (tip_number_i == '0) && (tip_digest_i == '0))
    else $error("tip set without tip valid");

endmodule

bind fifo_window_duplicate_filter fwf_checker #(
  .WINDOW (WINDOW)
) u_fwf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .was_present_i (out_o.was_present),
  .entry_count_i (out_o.entry_count),
  .tip_number_i  (out_o.tip_number),
  .tip_valid_i   (out_o.tip_valid),
  .tip_digest_i  ({out_o.tip_word_3, out_o.tip_word_2, out_o.tip_word_1,
                   out_o.tip_word_0})
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the FIFO-window duplicate filter
// Drives mark, query, clear and spare-mode words over several window sizes.
// Every accepted word is predicted in a scoreboard, and each result word is
// compared field by field. Both handshake sides idle at random. One long
// output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import fwf_pkg::*;

  localparam int         Window     = 256;
  localparam logic [1:0] ModeSpare  = 2'd3;
  localparam int         HoldCycles = 1500;
  localparam int         PoolDepth  = 32;
  localparam int         Phases     = 10;
  localparam int         PhaseSize [Phases] = '{1, 2, 3, 7, 0, 16, 511, 256, 64, 5};
  localparam int         PhaseLen  [Phases] = '{80, 80, 100, 120, 150, 150, 120, 330, 150, 100};
  localparam int         PhaseFresh[Phases] = '{50, 50, 50, 50, 50, 50, 50, 85, 60, 50};

  typedef struct packed {
    logic [1:0]  mode;
    hash_t       hash;
    logic [63:0] number;
  } filter_item_t;

  typedef struct packed {
    logic        was_present;
    logic [8:0]  entry_count;
    logic [63:0] tip_number;
    logic        tip_valid;
    hash_t       tip_digest;
  } filter_result_t;

  // Scoreboard: mirrors the window and tip, queues expected result words.
  class hash_window_board;
    hash_t          cells[Window];
    int             held;
    int             oldest;
    logic [8:0]     size_reg;
    logic [63:0]    tip_number;
    logic           tip_valid;
    hash_t          tip_digest;
    filter_result_t pending[$];
    int             failures;

    function new();
      failures = 0;
      set_size(9'(Window));
    endfunction

    function void clear_state();
      held       = 0;
      oldest     = 0;
      tip_number = '0;
      tip_valid  = 1'b0;
      tip_digest = '0;
    endfunction

    function void set_size(logic [8:0] value);
      size_reg = value;
      clear_state();
    endfunction

    function int span();
      if (size_reg == 0 || size_reg > Window) return Window;
      return int'(size_reg);
    endfunction

    function void note_word(filter_item_t item);
      filter_result_t res;
      logic           hit;
      hit = 1'b0;
      if (item.mode == MODE_CLEAR) begin
        clear_state();
      end else begin
        for (int i = 0; i < held; i++) begin
          if (cells[i] == item.hash) hit = 1'b1;
        end
        if (item.mode == MODE_MARK && !hit) begin
          if (held >= span()) begin
            // evict the oldest slot and advance the ring pointer
            if (oldest >= span()) oldest = 0;
            cells[oldest] = item.hash;
            oldest = (oldest + 1 >= span()) ? 0 : oldest + 1;
          end else begin
            cells[held] = item.hash;
            held++;
          end
          if (item.number > tip_number) begin
            tip_number = item.number;
            tip_valid  = 1'b1;
            tip_digest = item.hash;
          end
        end
      end
      res.was_present = hit;
      res.entry_count = 9'(held);
      res.tip_number  = tip_number;
      res.tip_valid   = tip_valid;
      res.tip_digest  = tip_digest;
      pending.push_back(res);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_word(filter_result_t got);
      filter_result_t want;
      if (pending.size() == 0) begin
        $error("result word arrived with nothing expected");
        failures++;
        return;
      end
      want = pending.pop_front();
      compare("was_present", 64'(want.was_present), 64'(got.was_present));
      compare("entry_count", 64'(want.entry_count), 64'(got.entry_count));
      compare("tip_number", want.tip_number, got.tip_number);
      compare("tip_valid", 64'(want.tip_valid), 64'(got.tip_valid));
      for (int w = 0; w < HashWords; w++) begin
        compare($sformatf("tip_word_%0d", w), want.tip_digest[w], got.tip_digest[w]);
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  fwf_in_if  in_ch ();
  fwf_out_if out_ch ();

  fifo_window_duplicate_filter #(
    .WINDOW(Window)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  hash_window_board board;
  bit               steady;
  bit               hold_request;
  logic [63:0]      height;
  hash_t            pool[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic hash_t fresh_hash();
    hash_t h;
    for (int w = 0; w < HashWords; w++) h[w] = rand64();
    return h;
  endfunction

  // Mostly short gaps, a few long ones; none in steady phases.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 30);
    return $urandom_range(60, 200);
  endfunction

  // Fresh hash, a recent one (likely still held), or a one-bit near miss.
  function automatic hash_t pick_hash(int fresh_pct);
    hash_t h;
    int    r;
    r = $urandom_range(0, 99);
    if (pool.size() == 0 || r < fresh_pct) begin
      h = fresh_hash();
    end else begin
      h = pool[$urandom_range(0, pool.size() - 1)];
      if (r >= 90) h[$urandom_range(0, HashWords - 1)][$urandom_range(0, 63)] ^= 1'b1;
    end
    pool.push_back(h);
    if (pool.size() > PoolDepth) void'(pool.pop_front());
    return h;
  endfunction

  // Mostly a slowly rising height, with stale, zero and wild numbers mixed in.
  function automatic logic [63:0] pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 4) return rand64();
    if (r < 20) return height - 64'($urandom_range(0, 50));
    height += 64'($urandom_range(0, 3));
    return height;
  endfunction

  task automatic send_word(logic [1:0] mode, hash_t hash, logic [63:0] number);
    filter_item_t item;
    int           gap;
    item.mode   = mode;
    item.hash   = hash;
    item.number = number;
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.hash_word_0  <= hash[0];
    in_ch.hash_word_1  <= hash[1];
    in_ch.hash_word_2  <= hash[2];
    in_ch.hash_word_3  <= hash[3];
    in_ch.blk_height   <= number;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_word(item);
    gap = idle_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain: drop valid and wait for every expected result word.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(logic [8:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    board.set_size(value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : result_sink
    filter_result_t got;
    int             stall;
    int             hold;
    stall = 0;
    hold  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.was_present = out_ch.was_present;
        got.entry_count = out_ch.entry_count;
        got.tip_number  = out_ch.tip_number;
        got.tip_valid   = out_ch.tip_valid;
        got.tip_digest  = {out_ch.tip_word_3, out_ch.tip_word_2,
                           out_ch.tip_word_1, out_ch.tip_word_0};
        board.check_word(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        stall = idle_length();
        out_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin : stimulus
    hash_t      ones;
    hash_t      zeros;
    hash_t      spare;
    hash_t      probe;
    hash_t      first;
    hash_t      second;
    logic [1:0] mode;
    int         r;
    board = new();
    steady       = 1'b0;
    hold_request = 1'b0;
    height       = 64'd1000;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_QUERY;
    in_ch.hash_word_0  <= '0;
    in_ch.hash_word_1  <= '0;
    in_ch.hash_word_2  <= '0;
    in_ch.hash_word_3  <= '0;
    in_ch.blk_height   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ones  = '1;
    zeros = '0;
    spare = fresh_hash();
    send_word(MODE_QUERY, zeros, '0);
    send_word(MODE_MARK, zeros, '0);         // block zero never raises the tip
    send_word(MODE_MARK, zeros, 64'd5);      // duplicate: tip stays put
    send_word(MODE_MARK, ones, '1);
    send_word(MODE_MARK, spare, 64'd7);      // lower number: tip stays put
    send_word(MODE_QUERY, ones, '0);
    for (int w = 0; w < HashWords; w++) begin
      probe = ones;
      probe[w] = '0;
      send_word(MODE_QUERY, probe, '0);
    end
    send_word(ModeSpare, ones, 64'd9);       // spare mode acts as query
    probe = fresh_hash();
    send_word(ModeSpare, probe, 64'd9);
    send_word(MODE_QUERY, probe, '0);
    send_word(MODE_MARK, {HashWords{64'h5555_5555_5555_5555}}, 64'h5555_5555_5555_5555);
    send_word(MODE_MARK, {HashWords{64'haaaa_aaaa_aaaa_aaaa}}, 64'haaaa_aaaa_aaaa_aaaa);
    send_word(MODE_CLEAR, ones, '1);         // clear reports absent even if held
    send_word(MODE_QUERY, ones, '0);
    send_word(MODE_MARK, ones, '0);
    send_word(MODE_MARK, spare, 64'd1);
    send_word(MODE_MARK, probe, 64'd1);      // equal number: no tip update
    send_word(MODE_MARK, zeros, 64'd2);
    send_word(MODE_QUERY, ones, '0);

    // single-entry window: each new mark evicts the previous one
    settle();
    write_size(9'd1);
    first  = fresh_hash();
    second = fresh_hash();
    send_word(MODE_MARK, first, 64'd3);
    send_word(MODE_MARK, second, 64'd4);
    send_word(MODE_QUERY, first, '0);
    send_word(MODE_QUERY, second, '0);

    for (int p = 0; p < Phases; p++) begin
      settle();
      write_size(9'(PhaseSize[p]));
      steady = (p % 3 == 2);
      pool.delete();
      // back the block up once while the window is at full size
      if (PhaseSize[p] == Window) hold_request = 1'b1;
      repeat (PhaseLen[p]) begin
        r = $urandom_range(0, 99);
        if (r < 3) mode = MODE_CLEAR;
        else if (r < 6) mode = ModeSpare;
        else if (r < 30) mode = MODE_QUERY;
        else mode = MODE_MARK;
        send_word(mode, pick_hash(PhaseFresh[p]), pick_number());
      end
    end

    settle();
    repeat (Window + 10) @(posedge clk_i);
    if (board.failures == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
